// ----- rtl/core/hrds_pkg.sv -----
// Shared types for the HID report descriptor scan unit.
`default_nettype none

package hrds_pkg;

  // One descriptor byte as it enters the unit.
  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_item_t;

  // One scan result per descriptor.
  typedef struct packed {
    logic [6:0]  addr_out;
    logic [7:0]  iface_out;
    logic        kbd_present;
    logic        ptr_present;
    logic [15:0] input_report_bytes;
  } out_item_t;

  // Item classes the front end tells the back end about.
  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_USAGE_PAGE,
    KIND_USAGE,
    KIND_REPORT_SIZE,
    KIND_REPORT_COUNT,
    KIND_INPUT
  } item_kind_e;

  // Finished short item, handed from front to back.
  typedef struct packed {
    logic       last;
    item_kind_e kind;
    logic [7:0] data;
  } event_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] interface_number;
    logic       start_keyboard;
    logic       start_mouse;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/hrds_fifo.sv -----
// Small register-based queue used between the scan stages and at the output.
`default_nettype none

module hrds_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrds_front.sv -----
// Front end: splits descriptor bytes into short items and classifies them.
`default_nettype none

module hrds_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire hrds_pkg::in_item_t item_i,
  output logic                    ev_valid_o,
  output hrds_pkg::event_t        ev_o
);

  import hrds_pkg::*;

  localparam logic [7:0] TagMask        = 8'hFC;
  localparam logic [7:0] TagUsagePage   = 8'h05 & TagMask;
  localparam logic [7:0] TagUsage       = 8'h09 & TagMask;
  localparam logic [7:0] TagReportSize  = 8'h75 & TagMask;
  localparam logic [7:0] TagReportCount = 8'h95 & TagMask;
  localparam logic [7:0] TagInput       = 8'h81 & TagMask;
  localparam logic [1:0] SizeMask       = 2'b11;

  function automatic item_kind_e classify(input logic [7:0] prefix);
    item_kind_e k;
    unique case (prefix & TagMask)
      TagUsagePage:   k = KIND_USAGE_PAGE;
      TagUsage:       k = KIND_USAGE;
      TagReportSize:  k = KIND_REPORT_SIZE;
      TagReportCount: k = KIND_REPORT_COUNT;
      TagInput:       k = KIND_INPUT;
      default:        k = KIND_OTHER;
    endcase
    return k;
  endfunction

  logic [1:0]  pend_q, pend_d;     // data bytes still due, 0 = prefix next
  logic        first_q, first_d;   // next data byte is the low byte
  item_kind_e  kind_q, kind_d;
  logic [7:0]  low_q, low_d;
  item_kind_e  kind_new;
  logic [7:0]  low_v;

  always_comb begin
    pend_d     = pend_q;
    first_d    = first_q;
    kind_d     = kind_q;
    low_d      = low_q;
    ev_valid_o = 1'b0;
    ev_o.last  = item_i.last_byte;
    ev_o.kind  = kind_q;
    ev_o.data  = 8'h00;
    kind_new   = classify(item_i.desc_byte);
    low_v      = first_q ? item_i.desc_byte : low_q;
    if (accept_i) begin
      if (pend_q == 2'd0) begin
        ev_o.kind = kind_new;
        if (((item_i.desc_byte[1:0] & SizeMask) == 2'd0) || item_i.last_byte) begin
          // no data, or descriptor ends right after the prefix: missing bytes are zero
          ev_valid_o = 1'b1;
        end else begin
          pend_d  = item_i.desc_byte[1:0] & SizeMask;
          first_d = 1'b1;
          kind_d  = kind_new;
          low_d   = 8'h00;
        end
      end else begin
        if ((pend_q == 2'd1) || item_i.last_byte) begin
          ev_valid_o = 1'b1;
          ev_o.data  = low_v;
          pend_d     = 2'd0;
        end else begin
          pend_d  = pend_q - 2'd1;
          first_d = 1'b0;
          low_d   = low_v;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      first_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    low_q  <= low_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrds_back.sv -----
// Back end: applies classified items to the scan state and builds the result.
`default_nettype none

module hrds_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrds_pkg::cfg_t    cfg_i,
  input  wire logic              ev_avail_i,
  input  wire hrds_pkg::event_t  ev_i,
  output logic                   ev_pop_o,
  input  wire logic              res_ready_i,
  output logic                   res_push_o,
  output hrds_pkg::out_item_t    res_o
);

  import hrds_pkg::*;

  localparam logic [7:0]  PageDesktop   = 8'h01;
  localparam logic [7:0]  PageKeyboard  = 8'h07;
  localparam logic [7:0]  UsageKeyboard = 8'h06;
  localparam logic [7:0]  UsageMouse    = 8'h02;
  localparam logic [7:0]  UsagePointer  = 8'h01;
  localparam logic [16:0] BitsRound     = 17'd7;
  localparam logic [15:0] TotalMax      = 16'hFFFF;

  logic [7:0]  page_q, page_d, page_n;
  logic [7:0]  size_q, size_d, size_n;
  logic [7:0]  count_q, count_d, count_n;
  logic        kb_q, kb_d, kb_n;
  logic        ms_q, ms_d, ms_n;
  logic [15:0] total_q, total_d, total_n;
  logic [15:0] prod;
  logic [16:0] rounded;
  logic [13:0] field;
  logic [16:0] sum;

  assign ev_pop_o   = ev_avail_i && (!ev_i.last || res_ready_i);
  assign res_push_o = ev_pop_o && ev_i.last;

  // Input item size in bytes: ceil(size * count / 8)
  assign prod    = 16'(size_q) * 16'(count_q);
  assign rounded = 17'(prod) + BitsRound;
  assign field   = rounded[16:3];
  assign sum     = 17'(total_q) + 17'(field);

  always_comb begin
    page_n  = page_q;
    size_n  = size_q;
    count_n = count_q;
    kb_n    = kb_q;
    ms_n    = ms_q;
    total_n = total_q;
    unique case (ev_i.kind)
      KIND_USAGE_PAGE:   page_n = ev_i.data;
      KIND_USAGE: begin
        if (page_q == PageDesktop) begin
          if (ev_i.data == UsageKeyboard) begin
            kb_n = 1'b1;
          end else if ((ev_i.data == UsageMouse) || (ev_i.data == UsagePointer)) begin
            ms_n = 1'b1;
          end
        end else if (page_q == PageKeyboard) begin
          kb_n = 1'b1;
        end
      end
      KIND_REPORT_SIZE:  size_n  = ev_i.data;
      KIND_REPORT_COUNT: count_n = ev_i.data;
      KIND_INPUT: begin
        if ({2'b00, field} > total_q) begin
          total_n = sum[16] ? TotalMax : sum[15:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.addr_out           = cfg_i.dev_addr;
    res_o.iface_out          = cfg_i.interface_number;
    res_o.kbd_present        = kb_n | cfg_i.start_keyboard;
    res_o.ptr_present        = ms_n | cfg_i.start_mouse;
    res_o.input_report_bytes = total_n;

    page_d  = page_q;
    size_d  = size_q;
    count_d = count_q;
    kb_d    = kb_q;
    ms_d    = ms_q;
    total_d = total_q;
    if (ev_pop_o) begin
      if (ev_i.last) begin
        page_d  = 8'h00;
        size_d  = 8'h00;
        count_d = 8'h00;
        kb_d    = 1'b0;
        ms_d    = 1'b0;
        total_d = 16'h0000;
      end else begin
        page_d  = page_n;
        size_d  = size_n;
        count_d = count_n;
        kb_d    = kb_n;
        ms_d    = ms_n;
        total_d = total_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= 8'h00;
      size_q  <= 8'h00;
      count_q <= 8'h00;
      kb_q    <= 1'b0;
      ms_q    <= 1'b0;
      total_q <= 16'h0000;
    end else begin
      page_q  <= page_d;
      size_q  <= size_d;
      count_q <= count_d;
      kb_q    <= kb_d;
      ms_q    <= ms_d;
      total_q <= total_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hid_report_descriptor_scan_unit.sv -----
// Top level of the HID report descriptor scan unit.
// Throughput: one byte per cycle unless full; back end: one item a cycle unless blocked.
// A last byte's event goes into the event queue; its result then enters the result queue.
// The event queue (EvqDepth) and result queue (ResDepth) decouple the two sides.
// Reset: registers read 0, both queues empty, scan state cleared; no clearing pass.
`default_nettype none

module hid_report_descriptor_scan_unit #(
  parameter int unsigned EvqDepth = 4,
  parameter int unsigned ResDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // descriptor bytes in
  input  wire logic                push,
  output logic                     full,
  input  wire hrds_pkg::in_item_t  in_item_i,
  // results out
  output logic                     empty,
  input  wire logic                pop,
  output hrds_pkg::out_item_t      out_item_o,
  // register writes
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [7:0]          cfg_wdata_i
);

  import hrds_pkg::*;

  // register indexes
  localparam logic [1:0] CfgDevAddr         = 2'd0;
  localparam logic [1:0] CfgInterfaceNumber = 2'd1;
  localparam logic [1:0] CfgStartKeyboard   = 2'd2;
  localparam logic [1:0] CfgStartMouse      = 2'd3;

  localparam int unsigned EvW  = $bits(event_t);
  localparam int unsigned ResW = $bits(out_item_t);

  cfg_t      cfg_q, cfg_d;
  logic      in_accept;
  logic      ev_valid;
  event_t    ev_new;
  logic      evq_full;
  logic      evq_empty;
  logic [EvW-1:0] evq_rdata;
  event_t    ev_head;
  logic      ev_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_new;
  logic [ResW-1:0] res_rdata;

  // Config register file. Write only while the unit is idle; the block itself does not enforce this.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDevAddr:         cfg_d.dev_addr         = cfg_wdata_i[6:0];
        CfgInterfaceNumber: cfg_d.interface_number = cfg_wdata_i;
        CfgStartKeyboard:   cfg_d.start_keyboard   = cfg_wdata_i[0];
        CfgStartMouse:      cfg_d.start_mouse      = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Every byte yields at most one event, so a free event slot is all a byte needs.
  assign full      = evq_full;
  assign in_accept = push && !full;

  hrds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .item_i     (in_item_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev_new)
  );

  hrds_fifo #(
    .Width (EvW),
    .Depth (EvqDepth)
  ) u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .data_i  (ev_new),
    .full_o  (evq_full),
    .pop_i   (ev_pop),
    .data_o  (evq_rdata),
    .empty_o (evq_empty)
  );

  assign ev_head = event_t'(evq_rdata);

  hrds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_avail_i  (!evq_empty),
    .ev_i        (ev_head),
    .ev_pop_o    (ev_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  // Result queue: doubles as the output register.
  hrds_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(res_rdata);

  // Front never produces an event into a full queue.
  a_evq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> !evq_full)
    else $error("event pushed into full event queue");

  // Back end only retires an item that is there.
  a_back_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_pop |-> !evq_empty)
    else $error("back end popped empty event queue");

  // A result is built only when the result queue has room, and only on a last item.
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!res_full && ev_head.last))
    else $error("result pushed without room or without last item");

endmodule

`default_nettype wire

// ----- tb/sv/hid_report_descriptor_scan_unit_tb.sv -----
// Self-checking testbench for the HID report descriptor scan unit.
module hid_report_descriptor_scan_unit_tb;
  import hrds_pkg::*;

  // Short item prefix layout: two low bits give the data length, the rest
  // is the tag. Tags are kept with the size bits cleared.
  localparam logic [7:0] SIZE_BITS        = 8'h03;
  localparam logic [7:0] TAG_MASK         = 8'hFC;
  localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
  localparam logic [7:0] TAG_USAGE        = 8'h08;
  localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
  localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;
  localparam logic [7:0] TAG_INPUT        = 8'h80;
  localparam logic [7:0] TAG_LONG         = 8'hFC;  // long-item prefix, parsed as short

  // Usage pages and usages that drive the device flags.
  localparam logic [7:0] PAGE_DESKTOP   = 8'h01;
  localparam logic [7:0] PAGE_KEYBOARD  = 8'h07;
  localparam logic [7:0] USAGE_POINTER  = 8'h01;
  localparam logic [7:0] USAGE_MOUSE    = 8'h02;
  localparam logic [7:0] USAGE_KEYBOARD = 8'h06;

  localparam int unsigned TOTAL_MAX = 65535;

  // Register map of the write port.
  localparam logic [1:0] REG_DEV_ADDR         = 2'd0;
  localparam logic [1:0] REG_INTERFACE_NUMBER = 2'd1;
  localparam logic [1:0] REG_START_KEYBOARD   = 2'd2;
  localparam logic [1:0] REG_START_MOUSE      = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  hid_report_descriptor_scan_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shared run control.
  int          error_count = 0;
  int unsigned bytes_sent  = 0;
  bit          idle_en     = 1'b1;  // random gaps on both sides
  int unsigned hold_cycles = 0;     // long receiver hold, counted down by the receiver

  // Expected scan reports, oldest first.
  out_item_t   expected_reports[$];
  // Descriptor under construction, sent as one unit with last on its final byte.
  logic [7:0]  desc_buf[$];

  // Predictor copy of the register file.
  logic [6:0] addr_cfg    = '0;
  logic [7:0] iface_cfg   = '0;
  logic       kb_preset   = 1'b0;
  logic       mouse_preset = 1'b0;

  // Predictor copy of the scan state.
  logic [1:0]  need_bytes  = '0;
  logic [1:0]  data_pos    = '0;
  logic [7:0]  item_prefix = '0;
  logic [23:0] item_data   = '0;
  logic [7:0]  cur_page    = '0;
  logic [7:0]  cur_size    = '0;
  logic [7:0]  cur_count   = '0;
  logic        kb_flag     = 1'b0;
  logic        mouse_flag  = 1'b0;
  logic [15:0] rpt_total   = '0;

  // Apply one complete (or zero-padded) short item to the globals and flags.
  function automatic void close_item();
    logic [7:0]  lo;
    int unsigned field;
    int unsigned sum;
    lo = item_data[7:0];
    case (item_prefix & TAG_MASK)
      TAG_USAGE_PAGE: cur_page = lo;
      TAG_USAGE: begin
        if (cur_page == PAGE_DESKTOP) begin
          if (lo == USAGE_KEYBOARD) kb_flag = 1'b1;
          else if (lo == USAGE_MOUSE || lo == USAGE_POINTER) mouse_flag = 1'b1;
        end else if (cur_page == PAGE_KEYBOARD) begin
          kb_flag = 1'b1;
        end
      end
      TAG_REPORT_SIZE:  cur_size  = lo;
      TAG_REPORT_COUNT: cur_count = lo;
      TAG_INPUT: begin
        if (cur_size != 0 && cur_count != 0) begin
          // bits rounded up to whole bytes; only a larger field is added
          field = (32'(cur_size) * 32'(cur_count) + 7) / 8;
          if (field > rpt_total) begin
            sum = 32'(rpt_total) + field;
            rpt_total = (sum > TOTAL_MAX) ? 16'hFFFF : sum[15:0];
          end
        end
      end
      default: ;
    endcase
    need_bytes = '0;
    data_pos   = '0;
    item_data  = '0;
  endfunction

  // Advance the predicted scan by one accepted byte; a last byte yields a report.
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    out_item_t rpt;
    if (need_bytes == 0) begin
      item_prefix = b;
      need_bytes  = 2'(b & SIZE_BITS);
      data_pos    = '0;
      item_data   = '0;
      if (need_bytes == 0) close_item();
    end else begin
      item_data  = item_data | (24'(b) << (8 * data_pos));
      data_pos   = data_pos + 2'd1;
      need_bytes = need_bytes - 2'd1;
      if (need_bytes == 0) close_item();
    end
    if (last) begin
      // truncated item: missing data bytes read as zero
      if (need_bytes != 0) close_item();
      rpt.addr_out           = addr_cfg;
      rpt.iface_out          = iface_cfg;
      rpt.kbd_present        = kb_flag | kb_preset;
      rpt.ptr_present        = mouse_flag | mouse_preset;
      rpt.input_report_bytes = rpt_total;
      expected_reports.push_back(rpt);
      item_prefix = '0;
      cur_page    = '0;
      cur_size    = '0;
      cur_count   = '0;
      kb_flag     = 1'b0;
      mouse_flag  = 1'b0;
      rpt_total   = '0;
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item; inputs move on the falling edge, acceptance is seen on
  // the rising edge. Push stays high into the next item unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push              <= 1'b1;
    in_item.desc_byte <= b;
    in_item.last_byte <= last;
    do @(posedge clk_i); while (full);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  // Append one short item: prefix then its little-endian data bytes.
  function automatic void add_item(input logic [7:0] tag, input logic [1:0] size,
                                   input logic [23:0] value);
    desc_buf.push_back(tag | 8'(size));
    for (int i = 0; i < size; i++) desc_buf.push_back(value[8*i +: 8]);
  endfunction

  task automatic send_desc();
    for (int i = 0; i < desc_buf.size(); i++) send_byte(desc_buf[i], i == desc_buf.size() - 1);
    desc_buf.delete();
  endtask

  // Mostly well-formed descriptor with random content; sometimes the tail is
  // cut so the last byte lands inside an item.
  function automatic void build_descriptor();
    int unsigned n_items;
    int unsigned pick;
    int unsigned r;
    logic [1:0]  sz;
    logic [23:0] val;
    logic [7:0]  tag;
    n_items = $urandom_range(1, 10);
    repeat (n_items) begin
      pick = $urandom_range(0, 9);
      r    = $urandom_range(0, 3);
      sz   = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : 2'd1;
      val  = 24'($urandom);
      case (pick)
        0, 1: begin
          tag = TAG_USAGE_PAGE;
          val[7:0] = (r < 2) ? PAGE_DESKTOP : (r == 2) ? PAGE_KEYBOARD : 8'($urandom);
        end
        2, 3: begin
          tag = TAG_USAGE;
          val[7:0] = (r == 0) ? USAGE_POINTER : (r == 1) ? USAGE_MOUSE :
                     (r == 2) ? USAGE_KEYBOARD : 8'($urandom);
        end
        4: begin
          tag = TAG_REPORT_SIZE;
          val[7:0] = (r == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
        end
        5: begin
          tag = TAG_REPORT_COUNT;
          val[7:0] = (r == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
        end
        6, 7: tag = TAG_INPUT;
        default: tag = 8'($urandom) & TAG_MASK;
      endcase
      add_item(tag, sz, val);
    end
    if ($urandom_range(0, 4) == 0 && desc_buf.size() > 1) desc_buf.delete(desc_buf.size() - 1);
  endfunction

  // Register write; only issued while the unit is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEV_ADDR:         addr_cfg     = value[6:0];
      REG_INTERFACE_NUMBER: iface_cfg    = value;
      REG_START_KEYBOARD:   kb_preset    = value[0];
      REG_START_MOUSE:      mouse_preset = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] addr, input logic [7:0] iface,
                                input logic [7:0] kb, input logic [7:0] mouse);
    write_reg(REG_DEV_ADDR, addr);
    write_reg(REG_INTERFACE_NUMBER, iface);
    write_reg(REG_START_KEYBOARD, kb);
    write_reg(REG_START_MOUSE, mouse);
  endtask

  // Stop offering, let every expected report drain, then allow for bytes
  // still moving through the event queue before anything else happens.
  task automatic wait_idle();
    int unsigned n;
    @(negedge clk_i);
    push <= 1'b0;
    n = 0;
    while (expected_reports.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
      error_count++;
      expected_reports.delete();
    end
  endtask

  // Receiver: pops at random, with stall bursts and the long hold.
  initial begin : report_sink
    int unsigned stall;
    pop   = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Each popped report is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin : report_check
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual 0x%0h", $time, out_item);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("addr_out", want.addr_out, out_item.addr_out);
        check_field("iface_out", want.iface_out, out_item.iface_out);
        check_field("kbd_present", want.kbd_present, out_item.kbd_present);
        check_field("ptr_present", want.ptr_present, out_item.ptr_present);
        check_field("input_report_bytes", want.input_report_bytes,
                    out_item.input_report_bytes);
      end
    end
  end

  // Hand-built descriptors: max field size, desktop-page flag paths, multi-byte data,
  // long-item prefix, truncation, one-byte descriptors.
  task automatic test_directed_items();
    // keyboard with the largest size times count
    add_item(TAG_USAGE_PAGE, 2'd1, 24'(PAGE_DESKTOP));
    add_item(TAG_USAGE, 2'd1, 24'(USAGE_KEYBOARD));
    add_item(TAG_REPORT_SIZE, 2'd1, 24'hFF);
    add_item(TAG_REPORT_COUNT, 2'd2, 24'h0000FF);
    add_item(TAG_INPUT, 2'd1, 24'h02);
    send_desc();
    // mouse, pointer with 2-byte data, long prefix, input with no size,
    // then a count item whose data byte never comes
    add_item(TAG_USAGE_PAGE, 2'd1, 24'(PAGE_DESKTOP));
    add_item(TAG_USAGE, 2'd1, 24'(USAGE_MOUSE));
    add_item(TAG_USAGE, 2'd2, 24'(USAGE_POINTER));
    add_item(TAG_LONG, 2'd2, 24'h001234);
    add_item(TAG_INPUT, 2'd0, 24'h0);
    desc_buf.push_back(TAG_REPORT_COUNT | 8'd1);
    send_desc();
    // single-byte descriptors at both byte extremes
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Register extremes and preset combinations, each with a short descriptor.
  task automatic test_config_extremes();
    wait_idle();
    write_all_regs(8'hFF, 8'hFF, 8'h01, 8'h01);
    build_descriptor();
    send_desc();
    wait_idle();
    write_all_regs(8'h00, 8'h00, 8'h00, 8'h00);
    add_item(TAG_USAGE_PAGE, 2'd1, 24'(PAGE_KEYBOARD));
    add_item(TAG_USAGE, 2'd0, 24'h0);
    send_desc();
    wait_idle();
    write_all_regs(8'h7F, 8'h80, 8'h00, 8'hFF);
    build_descriptor();
    send_desc();
    wait_idle();
    write_all_regs(8'($urandom), 8'($urandom), 8'h01, 8'h00);
    build_descriptor();
    send_desc();
  endtask

  // Bulk random traffic in several register settings: mostly descriptors,
  // some raw noise with random last markers.
  task automatic test_random_descriptors();
    int unsigned target;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      target = bytes_sent + 110;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          build_descriptor();
          send_desc();
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while one-byte descriptors keep
  // coming, so both internal queues fill and full must hold the sender.
  task automatic test_output_backpressure();
    hold_cycles = 300;
    repeat (20) send_byte(8'($urandom), 1'b1);
    repeat (3) begin
      build_descriptor();
      send_desc();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_back_to_back();
    wait_idle();
    idle_en = 1'b0;
    repeat (12) begin
      build_descriptor();
      send_desc();
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_items();
    test_config_extremes();
    test_random_descriptors();
    test_output_backpressure();
    test_back_to_back();
    wait_idle();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
